// ===== hdl/sha1sh_pkg.sv =====
// Types, constants and helpers shared by the SHA-1 stream hasher modules.
`default_nettype none

package sha1sh_pkg;

   localparam int unsigned BlockWords = 16;
   localparam int unsigned HashWords  = 5;

   typedef logic [31:0] word_type;
   typedef logic [3:0]  widx_type;
   typedef logic [6:0]  round_type;
   typedef logic [2:0]  onum_type;

   localparam round_type LAST_ROUND = 7'd79;
   localparam round_type GRP1_START = 7'd20;
   localparam round_type GRP2_START = 7'd40;
   localparam round_type GRP3_START = 7'd60;

   localparam onum_type  LAST_WORD  = 3'd4;
   localparam widx_type  LAST_WIDX  = 4'd15;
   localparam widx_type  LEN_HI_IDX = 4'd14;
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;
   localparam logic [5:0] LEN_START_POS = 6'd56;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam word_type K0 = 32'h5A827999;
   localparam word_type K1 = 32'h6ED9EBA1;
   localparam word_type K2 = 32'h8F1BBCDC;
   localparam word_type K3 = 32'hCA62C1D6;

   localparam word_type H0 = 32'h67452301;
   localparam word_type H1 = 32'hEFCDAB89;
   localparam word_type H2 = 32'h98BADCFE;
   localparam word_type H3 = 32'h10325476;
   localparam word_type H4 = 32'hC3D2E1F0;

   // Initial chaining value for word position i.
   function automatic word_type init_h(input onum_type i);
      word_type h;
      unique case (i)
         3'd0:    h = H0;
         3'd1:    h = H1;
         3'd2:    h = H2;
         3'd3:    h = H3;
         default: h = H4;
      endcase
      return h;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLK,
      ST_PADW,
      ST_PCMP,
      ST_LENW,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_LOAD,
      CS_ROUND,
      CS_ADD
   } core_state_type;

   typedef struct packed {
      logic     start;
      logic     chain_init;
      logic     win_we;
      widx_type win_idx;
      word_type win_data;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

endpackage

`default_nettype wire

// ===== hdl/sha1sh_core.sv =====
// SHA-1 compression unit: schedule shift line, one round per cycle, chaining add.
`default_nettype none

module sha1sh_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sha1sh_pkg::core_ctl_type ctl,
   output sha1sh_pkg::core_sts_type    sts,
   output sha1sh_pkg::word_type [sha1sh_pkg::HashWords-1:0] chain_out
);

   sha1sh_pkg::core_state_type cst_ff, cst_in;
   sha1sh_pkg::round_type      rnd_ff, rnd_in;
   sha1sh_pkg::word_type       win_ff [sha1sh_pkg::BlockWords];
   sha1sh_pkg::word_type       a_ff, b_ff, c_ff, d_ff, e_ff;
   sha1sh_pkg::word_type       chain_ff [sha1sh_pkg::HashWords];

   sha1sh_pkg::word_type sched_x, sched_w, f_val, k_val, temp;

   // Next state
   always_comb begin
      cst_in = cst_ff;
      unique case (cst_ff)
         sha1sh_pkg::CS_IDLE:  if (ctl.start) cst_in = sha1sh_pkg::CS_LOAD;
         sha1sh_pkg::CS_LOAD:  cst_in = sha1sh_pkg::CS_ROUND;
         sha1sh_pkg::CS_ROUND: if (rnd_ff == sha1sh_pkg::LAST_ROUND) cst_in = sha1sh_pkg::CS_ADD;
         sha1sh_pkg::CS_ADD:   cst_in = sha1sh_pkg::CS_IDLE;
         default:              cst_in = sha1sh_pkg::CS_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      sts.busy = (cst_ff != sha1sh_pkg::CS_IDLE);
      sts.done = (cst_ff == sha1sh_pkg::CS_ADD);
      rnd_in   = (cst_ff == sha1sh_pkg::CS_ROUND) ? rnd_ff + 7'd1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cst_ff <= sha1sh_pkg::CS_IDLE;
         rnd_ff <= '0;
      end else begin
         cst_ff <= cst_in;
         rnd_ff <= rnd_in;
      end
   end

   // Window holds W[t..t+15] at round t; push W[t+16] each round.
   assign sched_x = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign sched_w = {sched_x[30:0], sched_x[31]};

   always_ff @(posedge clock) begin
      if (ctl.win_we) begin
         win_ff[ctl.win_idx] <= ctl.win_data;
      end else if (cst_ff == sha1sh_pkg::CS_ROUND) begin
         for (int i = 0; i < sha1sh_pkg::BlockWords - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[sha1sh_pkg::BlockWords-1] <= sched_w;
      end
   end

   always_comb begin
      priority if (rnd_ff < sha1sh_pkg::GRP1_START) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1sh_pkg::K0;
      end else if (rnd_ff < sha1sh_pkg::GRP2_START) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1sh_pkg::K1;
      end else if (rnd_ff < sha1sh_pkg::GRP3_START) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1sh_pkg::K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1sh_pkg::K3;
      end
   end

   assign temp = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + win_ff[0] + k_val;

   always_ff @(posedge clock) begin
      if (cst_ff == sha1sh_pkg::CS_LOAD) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cst_ff == sha1sh_pkg::CS_ROUND) begin
         a_ff <= temp;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.chain_init) begin
         for (int i = 0; i < sha1sh_pkg::HashWords; i++) begin
            chain_ff[i] <= sha1sh_pkg::init_h(3'(i));
         end
      end else if (cst_ff == sha1sh_pkg::CS_ADD) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
         chain_ff[4] <= chain_ff[4] + e_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < sha1sh_pkg::HashWords; i++) begin
         chain_out[i] = chain_ff[i];
      end
   end

   a_win_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.win_we |-> (cst_ff == sha1sh_pkg::CS_IDLE))
      else $error("schedule window written during compression");

   a_round_end : assert property (@(posedge clock) disable iff (reset)
      (cst_ff == sha1sh_pkg::CS_ROUND && rnd_ff == sha1sh_pkg::LAST_ROUND)
      |=> (cst_ff == sha1sh_pkg::CS_ADD))
      else $error("chaining add did not follow the last round");

   a_start : assert property (@(posedge clock) disable iff (reset)
      (ctl.start && cst_ff == sha1sh_pkg::CS_IDLE) |=> (cst_ff == sha1sh_pkg::CS_LOAD))
      else $error("start not taken");

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (cst_ff == sha1sh_pkg::CS_IDLE))
      else $error("start issued while busy");

endmodule

`default_nettype wire

// ===== hdl/sha1_stream_hasher_top.sv =====
// SHA-1 stream hasher top level: byte packing, padding sequencer and digest output.
//
// Usage: feed a message one byte per req_ word (req_has_byte=1 with req_data_byte).
// A word with req_end_of_message=1 closes the message; its byte, if any, is taken
// first. A word with neither byte nor end mark changes nothing.
// Input: req_ready stays high while a block fills; the 64th byte starts a
// compression (load, 80 rounds, chaining add) in the single round unit, during
// which req_ready is low. End of message: padding is written one schedule word
// per cycle, then one compression; when the end mark leaves 56 to 63 bytes in
// the block, a second block of zeros and the length is written and compressed.
// The five digest words then appear on rsp_ in order, word 0 first, with
// rsp_final_word set on word 4; each stays until rsp_ready takes it, and a stall
// on rsp_ simply holds the block. After word 4 is taken the chaining value and
// length return to their initial values and req_ready rises again.
// Reset (synchronous, active high) clears the sequencer, length and chain.
`default_nettype none

module sha1_stream_hasher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_number,
   output logic             rsp_final_word
);

   sha1sh_pkg::state_type    state_ff, state_in;
   logic [5:0]               fill_ff, fill_in;
   sha1sh_pkg::word_type     acc_ff, acc_in;
   logic [63:0]              bc_ff, bc_in;
   sha1sh_pkg::widx_type     pidx_ff, pidx_in;
   sha1sh_pkg::onum_type     onum_ff, onum_in;
   logic                     last_ff, last_in;

   sha1sh_pkg::core_ctl_type ctl;
   sha1sh_pkg::core_sts_type sts;
   sha1sh_pkg::word_type [sha1sh_pkg::HashWords-1:0] chain;

   logic                 req_acc, rsp_acc, byte_acc, blk_full;
   logic [4:0]           byte_sh;
   sha1sh_pkg::word_type pad_word, len_word, fill_word;

   assign req_acc  = req_valid && req_ready;
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign byte_acc = req_acc && req_has_byte;
   assign blk_full = (fill_ff == sha1sh_pkg::LAST_BYTE_POS);
   assign byte_sh  = {~fill_ff[1:0], 3'b000};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            if (byte_acc && blk_full) begin
               state_in = sha1sh_pkg::ST_BLK;
            end else if (req_acc && req_end_of_message) begin
               state_in = sha1sh_pkg::ST_PADW;
            end
         end
         sha1sh_pkg::ST_BLK: begin
            if (sts.done) state_in = last_ff ? sha1sh_pkg::ST_PADW : sha1sh_pkg::ST_IDLE;
         end
         sha1sh_pkg::ST_PADW: begin
            if (pidx_ff == sha1sh_pkg::LAST_WIDX) state_in = sha1sh_pkg::ST_PCMP;
         end
         sha1sh_pkg::ST_PCMP: begin
            if (sts.done) begin
               state_in = (fill_ff >= sha1sh_pkg::LEN_START_POS) ? sha1sh_pkg::ST_LENW
                                                                 : sha1sh_pkg::ST_OUT;
            end
         end
         sha1sh_pkg::ST_LENW: begin
            if (pidx_ff == sha1sh_pkg::LAST_WIDX) state_in = sha1sh_pkg::ST_PCMP;
         end
         sha1sh_pkg::ST_OUT: begin
            if (rsp_acc && onum_ff == sha1sh_pkg::LAST_WORD) state_in = sha1sh_pkg::ST_IDLE;
         end
         default: state_in = sha1sh_pkg::ST_IDLE;
      endcase
   end

   // Schedule words for padding
   always_comb begin
      len_word = pidx_ff[0] ? bc_ff[31:0] : bc_ff[63:32];
      if (fill_ff[1:0] == 2'd0) begin
         fill_word = {sha1sh_pkg::PAD_BYTE, 24'd0};
      end else begin
         fill_word = acc_ff | ({24'd0, sha1sh_pkg::PAD_BYTE} << byte_sh);
      end
      priority if (pidx_ff == fill_ff[5:2]) begin
         pad_word = fill_word;
      end else if (fill_ff < sha1sh_pkg::LEN_START_POS && pidx_ff >= sha1sh_pkg::LEN_HI_IDX) begin
         pad_word = len_word;
      end else begin
         pad_word = '0;
      end
   end

   always_comb begin
      if (fill_ff[1:0] == 2'd0) begin
         acc_in = {req_data_byte, 24'd0};
      end else begin
         acc_in = acc_ff | ({24'd0, req_data_byte} << byte_sh);
      end
   end

   // Outputs
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      ctl.start      = 1'b0;
      ctl.chain_init = 1'b0;
      ctl.win_we     = 1'b0;
      ctl.win_idx    = pidx_ff;
      ctl.win_data   = pad_word;
      unique case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctl.win_we   = byte_acc && (fill_ff[1:0] == 2'd3);
            ctl.win_idx  = fill_ff[5:2];
            ctl.win_data = acc_in;
            ctl.start    = byte_acc && blk_full;
         end
         sha1sh_pkg::ST_PADW: begin
            ctl.win_we = 1'b1;
            ctl.start  = (pidx_ff == sha1sh_pkg::LAST_WIDX);
         end
         sha1sh_pkg::ST_LENW: begin
            ctl.win_we   = 1'b1;
            ctl.win_data = (pidx_ff >= sha1sh_pkg::LEN_HI_IDX) ? len_word : '0;
            ctl.start    = (pidx_ff == sha1sh_pkg::LAST_WIDX);
         end
         sha1sh_pkg::ST_OUT: begin
            rsp_valid      = 1'b1;
            ctl.chain_init = rsp_acc && (onum_ff == sha1sh_pkg::LAST_WORD);
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      fill_in = fill_ff;
      bc_in   = bc_ff;
      last_in = last_ff;
      onum_in = onum_ff;
      if (state_ff == sha1sh_pkg::ST_IDLE) begin
         if (byte_acc) begin
            fill_in = fill_ff + 6'd1;
            bc_in   = bc_ff + 64'd8;
         end
         if (req_acc) last_in = req_end_of_message;
      end
      if (state_ff == sha1sh_pkg::ST_LENW || state_ff == sha1sh_pkg::ST_OUT) begin
         fill_in = '0;
      end
      if (state_ff == sha1sh_pkg::ST_OUT) begin
         bc_in = '0;
         if (rsp_acc) onum_in = (onum_ff == sha1sh_pkg::LAST_WORD) ? '0 : onum_ff + 3'd1;
      end
      unique case (state_ff)
         sha1sh_pkg::ST_PADW, sha1sh_pkg::ST_LENW: pidx_in = pidx_ff + 4'd1;
         sha1sh_pkg::ST_PCMP:                      pidx_in = '0;
         default:                                  pidx_in = fill_in[5:2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1sh_pkg::ST_IDLE;
         fill_ff  <= '0;
         bc_ff    <= '0;
         pidx_ff  <= '0;
         onum_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bc_ff    <= bc_in;
         pidx_ff  <= pidx_in;
         onum_ff  <= onum_in;
         last_ff  <= last_in;
      end
   end

   // Hold the partial word of the block.
   always_ff @(posedge clock) begin
      if (byte_acc) acc_ff <= acc_in;
   end

   assign rsp_digest_word = chain[onum_ff];
   assign rsp_word_number = onum_ff;
   assign rsp_final_word  = (onum_ff == sha1sh_pkg::LAST_WORD);

   sha1sh_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .chain_out (chain)
   );

   a_idle_core : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1sh_pkg::ST_IDLE) |-> !sts.busy)
      else $error("input taken while compression runs");

   a_msg_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_word)
      |=> (req_ready && fill_ff == 6'd0 && bc_ff == 64'd0))
      else $error("message state not cleared after digest");

   a_onum_range : assert property (@(posedge clock) disable iff (reset)
      onum_ff <= sha1sh_pkg::LAST_WORD)
      else $error("digest word number out of range");

   a_out_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(onum_ff)))
      else $error("digest word moved while stalled");

endmodule

`default_nettype wire

// ===== verif/sha1_stream_hasher_top_test.sv =====
// Self-checking testbench for the SHA-1 stream hasher with a built-in digest predictor.
`default_nettype none

module sha1_stream_hasher_top_test;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int DRAIN_CYCLES    = 200;
   localparam int RSP_HOLD_CYCLES = 300;

   typedef struct {
      sha1sh_pkg::word_type digest;
      sha1sh_pkg::onum_type number;
      logic                 last_flag;
   } digest_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_number;
   logic        rsp_final_word;

   // predictor state
   sha1sh_pkg::word_type init_chain [sha1sh_pkg::HashWords] =
      '{sha1sh_pkg::H0, sha1sh_pkg::H1, sha1sh_pkg::H2, sha1sh_pkg::H3, sha1sh_pkg::H4};
   sha1sh_pkg::word_type hash_chain [sha1sh_pkg::HashWords] =
      '{sha1sh_pkg::H0, sha1sh_pkg::H1, sha1sh_pkg::H2, sha1sh_pkg::H3, sha1sh_pkg::H4};
   sha1sh_pkg::word_type block_words [sha1sh_pkg::BlockWords];
   logic [5:0]           fill_pos = '0;
   logic [63:0]          msg_bits = '0;
   digest_entry_type     pending_digest [$];

   bit   pace_random = 1'b0;
   logic rsp_hold = 1'b0;
   event rsp_hold_ev;
   int   rsp_gap_left = 0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   words_sent = 0;
   int   msg_count = 0;
   int   byte_count = 0;
   int   digest_words_checked = 0;

   sha1_stream_hasher_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_number    (rsp_word_number),
      .rsp_final_word     (rsp_final_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   function automatic sha1sh_pkg::word_type rotl(input sha1sh_pkg::word_type v,
                                                 input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // One 80-round compression of block_words into hash_chain.
   function automatic void compress_block();
      sha1sh_pkg::word_type w [80];
      sha1sh_pkg::word_type a, b, c, d, e, f, k, t;
      int r;
      for (r = 0; r < 16; r++)
         w[r] = block_words[r];
      for (r = 16; r < 80; r++)
         w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = sha1sh_pkg::K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = sha1sh_pkg::K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1sh_pkg::K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1sh_pkg::K3;
         end
         t = rotl(a, 5) + f + e + k + w[r];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   // Pack a byte big-endian; the first byte of a word clears the rest of it.
   function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
      sha1sh_pkg::word_type shifted;
      shifted = sha1sh_pkg::word_type'(b) << (24 - 8 * pos[1:0]);
      if (pos[1:0] == 2'd0)
         block_words[pos[5:2]] = shifted;
      else
         block_words[pos[5:2]] |= shifted;
   endfunction

   function automatic void predict_digest(input logic [7:0] b, input logic hb, input logic eom);
      int i;
      digest_entry_type entry;
      if (hb) begin
         place_byte(fill_pos, b);
         msg_bits += 64'd8;
         fill_pos = fill_pos + 6'd1;
         byte_count++;
         if (fill_pos == 6'd0)
            compress_block();
      end
      if (!eom)
         return;
      place_byte(fill_pos, sha1sh_pkg::PAD_BYTE);
      for (i = int'(fill_pos[5:2]) + 1; i < sha1sh_pkg::BlockWords; i++)
         block_words[i] = '0;
      // no room for the length: it goes into a block of its own
      if (fill_pos >= sha1sh_pkg::LEN_START_POS) begin
         compress_block();
         for (i = 0; i < sha1sh_pkg::BlockWords; i++)
            block_words[i] = '0;
      end
      block_words[sha1sh_pkg::LEN_HI_IDX] = msg_bits[63:32];
      block_words[sha1sh_pkg::LAST_WIDX]  = msg_bits[31:0];
      compress_block();
      for (i = 0; i < sha1sh_pkg::HashWords; i++) begin
         entry.digest    = hash_chain[i];
         entry.number    = sha1sh_pkg::onum_type'(i);
         entry.last_flag = (sha1sh_pkg::onum_type'(i) == sha1sh_pkg::LAST_WORD);
         pending_digest.push_back(entry);
      end
      hash_chain = init_chain;
      fill_pos   = '0;
      msg_bits   = '0;
      msg_count++;
   endfunction

   function automatic void check_digest_word();
      digest_entry_type entry;
      digest_words_checked++;
      if (pending_digest.size() == 0) begin
         $error("unexpected digest word %h (word_number %0d)", rsp_digest_word,
                rsp_word_number);
         mismatch_count++;
         return;
      end
      entry = pending_digest.pop_front();
      if (rsp_digest_word !== entry.digest) begin
         $error("digest_word: expected %h, got %h", entry.digest, rsp_digest_word);
         mismatch_count++;
      end
      if (rsp_word_number !== entry.number) begin
         $error("word_number: expected %0d, got %0d", entry.number, rsp_word_number);
         mismatch_count++;
      end
      if (rsp_final_word !== entry.last_flag) begin
         $error("final_word: expected %0b, got %0b", entry.last_flag, rsp_final_word);
         mismatch_count++;
      end
   endfunction

   // Digest word receiver with random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_digest_word();
         if (rsp_hold || rsp_gap_left > 0) begin
            if (rsp_gap_left > 0)
               rsp_gap_left = rsp_gap_left - 1;
            rsp_ready <= 1'b0;
         end else if (pace_random && $urandom_range(0, 99) < 12) begin
            rsp_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off, counted here.
   initial begin
      forever begin
         @(rsp_hold_ev);
         rsp_hold <= 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!pace_random)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input logic [7:0] b, input logic hb, input logic eom);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_has_byte       <= hb;
      req_end_of_message <= eom;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      predict_digest(b, hb, eom);
      if (hb || eom)
         words_sent++;
   endtask

   // Random bytes; the end mark rides on the last byte or on a word of its own.
   task automatic send_message(input int len, input bit eom_alone);
      int i;
      for (i = 0; i < len; i++)
         send_word(8'($urandom), 1'b1, !eom_alone && i == len - 1);
      if (eom_alone || len == 0)
         send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic test_short_messages();
      pace_random = 1'b0;
      send_word(8'h00, 1'b0, 1'b0);
      // empty message; the byte is ignored
      send_word(8'hFF, 1'b0, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      pace_random = 1'b1;
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h55, 1'b0, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'hAA, 1'b0, 1'b1);
   endtask

   task automatic test_block_boundaries();
      pace_random = 1'b1;
      // end mark at byte 56: the length needs a block of its own
      send_message(56, 1'b0);
      // end mark on the byte that fills the block
      send_message(64, 1'b0);
   endtask

   task automatic test_output_backpressure();
      pace_random = 1'b0;
      -> rsp_hold_ev;
      send_message(2, 1'b0);
      send_message(1, 1'b1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_messages();
      test_block_boundaries();
      test_output_backpressure();
      req_valid <= 1'b0;
      while (pending_digest.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Hashed %0d messages, %0d bytes in all, incl. block-boundary lengths",
               msg_count, byte_count);
      $display("Checked %0d digest words under random stalls and a long hold-off",
               digest_words_checked);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/sha1sh_pkg.sv
hdl/sha1sh_core.sv
hdl/sha1_stream_hasher_top.sv
verif/sha1_stream_hasher_top_test.sv
